FILE: rtl/core/nearest_codeword_mse_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest codeword search
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CODEWORD_MSE_SEARCH_DEFINES_SVH
`define NEAREST_CODEWORD_MSE_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NCS_ASSERT_IMP(label, ante, cons)
`define NCS_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Types and constants shared by the nearest codeword search blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ncs_pkg;

    localparam int VALUE_BITS   = 16;
    localparam int MAG_W        = VALUE_BITS + 1;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int DIST_W       = 36;
    localparam int ROW_W        = 6;
    localparam int ELEM_W       = 4;
    localparam int ROWS_CFG_W   = 7;
    localparam int DIM_CFG_W    = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_DIM  = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;

    localparam logic CMD_CB_WRITE = 1'b0;
    localparam logic CMD_QUERY    = 1'b1;

    localparam logic [1:0] OP_CB_WRITE = 2'd0;
    localparam logic [1:0] OP_Q_WRITE  = 2'd1;
    localparam logic [1:0] OP_Q_SEARCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_IN_USE  = 2'd1;

    typedef struct packed {
        logic                         command;
        logic [ROW_W-1:0]             row_index;
        logic [ELEM_W-1:0]            element_index;
        logic signed [VALUE_BITS-1:0] sample_value;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0]  best_row;
        logic [DIST_W-1:0] best_distance;
    } t_result;

    typedef struct packed {
        logic [1:0]                   op;
        logic [ROW_W-1:0]             row_index;
        logic [ELEM_W-1:0]            element_index;
        logic signed [VALUE_BITS-1:0] sample_value;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
    } t_back_stat;

    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last_elem;
        logic                  last_row;
        logic [ROWS_CFG_W-1:0] row;
    } t_tag;

endpackage

`default_nettype wire

FILE: rtl/core/ncs_ram.sv
// ----------------------------------------------------------------------------
// ncs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/ncs_front.sv
// ----------------------------------------------------------------------------
// ncs_front
// Accepts input items, drops out-of-range ones and tags queries that complete.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_front #(
    parameter int MAX_ROWS = ncs_pkg::DEF_MAX_ROWS,
    parameter int MAX_DIM  = ncs_pkg::DEF_MAX_DIM
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [ncs_pkg::DIM_CFG_W-1:0]  i_dim,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire ncs_pkg::t_item                 i_in,
    input  wire ncs_pkg::t_q_stat               i_q_stat,
    output logic                                o_push,
    output ncs_pkg::t_job                       o_job
);

    logic          r_valid, n_valid;
    ncs_pkg::t_job r_job, n_job;
    logic          w_accept;
    logic          w_elem_ok;
    logic          w_row_ok;
    logic          w_keep;

    assign o_push     = r_valid && !i_q_stat.full;
    assign o_in_ready = !r_valid || !i_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_job      = r_job;

    always_comb begin
        w_elem_ok = 32'(i_in.element_index) < MAX_DIM;
        w_row_ok  = 32'(i_in.row_index) < MAX_ROWS;
        n_job.row_index     = i_in.row_index;
        n_job.element_index = i_in.element_index;
        n_job.sample_value  = i_in.sample_value;
        if (i_in.command == ncs_pkg::CMD_CB_WRITE) begin
            w_keep   = w_elem_ok && w_row_ok;
            n_job.op = ncs_pkg::OP_CB_WRITE;
        end else if ({1'b0, i_in.element_index} == i_dim - 5'd1) begin
            w_keep   = w_elem_ok;
            n_job.op = ncs_pkg::OP_Q_SEARCH;
        end else begin
            w_keep   = w_elem_ok;
            n_job.op = ncs_pkg::OP_Q_WRITE;
        end
        if (w_accept) begin
            n_valid = w_keep;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ncs_queue.sv
// ----------------------------------------------------------------------------
// ncs_queue
// Short job queue between the front end and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ncs_pkg::t_job    i_job,
    input  wire logic             i_pop,
    output ncs_pkg::t_job         o_job,
    output ncs_pkg::t_q_stat      o_stat
);

    ncs_pkg::t_job                    r_mem [ncs_pkg::QUEUE_DEPTH];
    logic [ncs_pkg::QUEUE_AW-1:0]     r_wptr, n_wptr;
    logic [ncs_pkg::QUEUE_AW-1:0]     r_rptr, n_rptr;
    logic [ncs_pkg::QUEUE_AW:0]       r_count, n_count;

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (ncs_pkg::QUEUE_AW + 1)'(i_push)
                          - (ncs_pkg::QUEUE_AW + 1)'(i_pop);
        o_stat.full  = r_count == (ncs_pkg::QUEUE_AW + 1)'(ncs_pkg::QUEUE_DEPTH);
        o_stat.empty = r_count == '0;
        o_job        = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ncs_back.sv
// ----------------------------------------------------------------------------
// ncs_back
// Executes queued jobs: stores codebook and query elements, runs the search
// with one squared difference per cycle and holds the result for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_back #(
    parameter int MAX_ROWS = ncs_pkg::DEF_MAX_ROWS,
    parameter int MAX_DIM  = ncs_pkg::DEF_MAX_DIM
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [ncs_pkg::ROWS_CFG_W-1:0] i_rows,
    input  wire logic [ncs_pkg::DIM_CFG_W-1:0]  i_dim,
    input  wire ncs_pkg::t_job                  i_job,
    input  wire ncs_pkg::t_q_stat               i_q_stat,
    output logic                                o_pop,
    output ncs_pkg::t_back_stat                 o_stat,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output ncs_pkg::t_result                    o_out
);

    localparam int CB_DEPTH = MAX_ROWS * MAX_DIM;
    localparam int CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
    localparam int Q_AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VB       = ncs_pkg::VALUE_BITS;
    localparam int MW       = ncs_pkg::MAG_W;
    localparam int DW       = ncs_pkg::DIST_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [ncs_pkg::ROWS_CFG_W-1:0]    r_row, n_row;
    logic [ncs_pkg::DIM_CFG_W-1:0]     r_elem, n_elem;
    logic [CB_AW-1:0]                  r_row_base, n_row_base;
    ncs_pkg::t_tag                     w_t0, r_t1, r_t2, r_t3, r_t4;
    logic [MW-1:0]                     r_mag, n_mag;
    logic [ncs_pkg::SQ_W-1:0]          r_sq;
    logic [DW-1:0]                     r_acc, n_acc;
    logic [DW:0]                       w_sum;
    logic [DW-1:0]                     r_best;
    logic [ncs_pkg::ROWS_CFG_W-1:0]    r_best_row;
    logic                              w_take;
    logic                              r_fin, n_fin;
    logic                              w_load;
    logic                              r_out_valid, n_out_valid;
    ncs_pkg::t_result                  r_out;

    logic                              w_cb_we;
    logic                              w_q_we;
    logic [CB_AW-1:0]                  w_cb_waddr;
    logic [CB_AW-1:0]                  w_cb_raddr;
    logic [Q_AW-1:0]                   w_q_waddr;
    logic [Q_AW-1:0]                   w_q_raddr;
    logic [VB-1:0]                     w_cb_rdata;
    logic [VB-1:0]                     w_q_rdata;
    logic signed [MW-1:0]              w_diff;

    assign o_pop      = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign w_cb_we    = o_pop && (i_job.op == ncs_pkg::OP_CB_WRITE);
    assign w_q_we     = o_pop && (i_job.op != ncs_pkg::OP_CB_WRITE);
    assign w_cb_waddr = CB_AW'(int'(i_job.row_index) * MAX_DIM + int'(i_job.element_index));
    assign w_q_waddr  = Q_AW'(i_job.element_index);
    assign w_cb_raddr = r_row_base + CB_AW'(r_elem);
    assign w_q_raddr  = Q_AW'(r_elem);

    ncs_ram #(
        .WIDTH (VB),
        .DEPTH (CB_DEPTH)
    ) u_cb_ram (
        .i_clk   (i_clk),
        .i_we    (w_cb_we),
        .i_waddr (w_cb_waddr),
        .i_wdata (i_job.sample_value),
        .i_raddr (w_cb_raddr),
        .o_rdata (w_cb_rdata)
    );

    ncs_ram #(
        .WIDTH (VB),
        .DEPTH (MAX_DIM)
    ) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (i_job.sample_value),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    always_comb begin
        w_t0.valid     = r_state == ST_SCAN;
        w_t0.first     = r_elem == '0;
        w_t0.last_elem = r_elem == i_dim - 5'd1;
        w_t0.last_row  = r_row == i_rows - 7'd1;
        w_t0.row       = r_row;

        n_state    = r_state;
        n_row      = r_row;
        n_elem     = r_elem;
        n_row_base = r_row_base;
        case (r_state)
            ST_IDLE: begin
                n_row      = '0;
                n_elem     = '0;
                n_row_base = '0;
                if (o_pop && (i_job.op == ncs_pkg::OP_Q_SEARCH)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_t0.last_elem) begin
                    n_elem     = '0;
                    n_row      = r_row + 7'd1;
                    n_row_base = r_row_base + CB_AW'(MAX_DIM);
                    if (w_t0.last_row) begin
                        n_state = ST_WAIT;
                    end
                end else begin
                    n_elem = r_elem + 5'd1;
                end
            end
            ST_WAIT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_diff = $signed({w_cb_rdata[VB-1], w_cb_rdata}) - $signed({w_q_rdata[VB-1], w_q_rdata});
        n_mag  = w_diff[MW-1] ? MW'(-w_diff) : MW'(w_diff);

        w_sum = {1'b0, r_acc} + (DW + 1)'(r_sq);
        if (r_t3.first) begin
            n_acc = DW'(r_sq);
        end else if (w_sum[DW]) begin
            n_acc = '1;
        end else begin
            n_acc = w_sum[DW-1:0];
        end

        w_take = r_t4.valid && r_t4.last_elem && ((r_t4.row == '0) || (r_acc < r_best));
        w_load = (r_state == ST_WAIT) && r_fin && (!r_out_valid || i_out_ready);

        if (w_load) begin
            n_fin = 1'b0;
        end else if (r_t4.valid && r_t4.last_elem && r_t4.last_row) begin
            n_fin = 1'b1;
        end else begin
            n_fin = r_fin;
        end

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_t1        <= '0;
            r_t2        <= '0;
            r_t3        <= '0;
            r_t4        <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_t1        <= w_t0;
            r_t2        <= r_t1;
            r_t3        <= r_t2;
            r_t4        <= r_t3;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
        r_row      <= n_row;
        r_elem     <= n_elem;
        r_row_base <= n_row_base;
        r_mag      <= n_mag;
        r_sq       <= r_mag * r_mag;
        if (r_t3.valid) begin
            r_acc <= n_acc;
        end
        if (w_take) begin
            r_best     <= r_acc;
            r_best_row <= r_t4.row;
        end
        if (w_load) begin
            r_out.best_row      <= r_best_row[ncs_pkg::ROW_W-1:0];
            r_out.best_distance <= r_best;
        end
    end

    assign o_stat.busy = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_codeword_mse_search.sv
// ----------------------------------------------------------------------------
// nearest_codeword_mse_search
// Vector quantizer: finds the stored codebook row nearest to a query vector.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle into a four-entry job queue while the
// queue is not full. Each codebook write and each query element that does not
// complete a query is stored by the search engine as it is popped. The element
// at position dim_in_use-1 of a query starts a search over rows_in_use *
// dim_in_use codebook elements, one at a time as set by the single
// multiply-accumulate unit and the one read port of the codebook RAM, then a
// pipeline drain. The result (lowest row index on a tie) is held in an output
// register while later jobs are executed; a following search waits only at its
// end if that register has not been taken. Configuration registers are to be
// written only while no job is queued or running; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_codeword_mse_search_defines.svh"

module nearest_codeword_mse_search #(
    parameter int MAX_ROWS = ncs_pkg::DEF_MAX_ROWS,
    parameter int MAX_DIM  = ncs_pkg::DEF_MAX_DIM
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire ncs_pkg::t_item                  i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output ncs_pkg::t_result                     o_out,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ncs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ncs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [ncs_pkg::ROWS_CFG_W-1:0] r_rows;
    logic [ncs_pkg::DIM_CFG_W-1:0]  r_dim;
    logic [ncs_pkg::ROWS_CFG_W-1:0] w_rows_eff;
    logic [ncs_pkg::DIM_CFG_W-1:0]  w_dim_eff;
    logic                           w_cfg_we;
    logic                           w_push;
    logic                           w_pop;
    ncs_pkg::t_job                  w_front_job;
    ncs_pkg::t_job                  w_queue_job;
    ncs_pkg::t_q_stat               w_q_stat;
    ncs_pkg::t_back_stat            w_back_stat;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (r_rows == '0) begin
            w_rows_eff = 7'd1;
        end else if (32'(r_rows) > MAX_ROWS) begin
            w_rows_eff = ncs_pkg::ROWS_CFG_W'(MAX_ROWS);
        end else begin
            w_rows_eff = r_rows;
        end
        if (r_dim == '0) begin
            w_dim_eff = 5'd1;
        end else if (32'(r_dim) > MAX_DIM) begin
            w_dim_eff = ncs_pkg::DIM_CFG_W'(MAX_DIM);
        end else begin
            w_dim_eff = r_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_dim  <= 5'd16;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                ncs_pkg::REG_ROWS_IN_USE: begin
                    r_rows <= i_cfg_data[ncs_pkg::ROWS_CFG_W-1:0];
                end
                ncs_pkg::REG_DIM_IN_USE: begin
                    r_dim <= i_cfg_data[ncs_pkg::DIM_CFG_W-1:0];
                end
                default: begin
                    r_rows <= r_rows;
                end
            endcase
        end
    end

    ncs_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_DIM  (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dim      (w_dim_eff),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    ncs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_queue_job),
        .o_stat  (w_q_stat)
    );

    ncs_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_DIM  (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rows      (w_rows_eff),
        .i_dim       (w_dim_eff),
        .i_job       (w_queue_job),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_stat      (w_back_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    `NCS_ASSERT_IMP(a_pop_needs_job, w_pop, !w_q_stat.empty)
    `NCS_ASSERT_IMP(a_result_after_search, $rose(o_out_valid), $past(w_back_stat.busy))
    `NCS_ASSERT_IMP(a_best_row_in_use, o_out_valid, 7'(o_out.best_row) < w_rows_eff)
    `NCS_ASSERT_NXT(a_full_blocks_push, w_q_stat.full && !w_pop, !w_q_stat.empty)

endmodule

`default_nettype wire

FILE: tb/tb_nearest_codeword_mse_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_codeword_mse_search
// Loads codebook rows and streams query vectors through the search block under
// a range of row and dimension settings. Both sides idle and stall at random.
// A behavioral search model predicts the nearest row and its squared distance
// for every completed query, and each result is checked against it in order.
// ----------------------------------------------------------------------------
module tb_nearest_codeword_mse_search;

    localparam logic [ncs_pkg::CFG_IDX_W-1:0]  REG_UNMAPPED_A = 2'd2;
    localparam logic [ncs_pkg::CFG_IDX_W-1:0]  REG_UNMAPPED_B = 2'd3;
    localparam logic [ncs_pkg::VALUE_BITS-1:0] POS_MAX        = 16'h7FFF;
    localparam logic [ncs_pkg::VALUE_BITS-1:0] NEG_MAX        = 16'h8000;
    localparam longint unsigned DIST_LIMIT = (64'd1 << ncs_pkg::DIST_W) - 64'd1;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    ncs_pkg::t_item                 i_in        = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    ncs_pkg::t_result               o_out;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ncs_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ncs_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    nearest_codeword_mse_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // search model state
    logic signed [ncs_pkg::VALUE_BITS-1:0]
        codebook [ncs_pkg::DEF_MAX_ROWS][ncs_pkg::DEF_MAX_DIM];
    logic signed [ncs_pkg::VALUE_BITS-1:0] query_vec [ncs_pkg::DEF_MAX_DIM];
    logic [ncs_pkg::ROWS_CFG_W-1:0]        rows_reg = 7'd64;
    logic [ncs_pkg::DIM_CFG_W-1:0]         dim_reg  = 5'd16;
    ncs_pkg::t_result                      nearest_expected [$];

    // stimulus state
    ncs_pkg::t_item items_to_send [$];
    bit    cb_loaded [ncs_pkg::DEF_MAX_ROWS][ncs_pkg::DEF_MAX_DIM];
    bit    q_loaded [ncs_pkg::DEF_MAX_DIM];
    int    items_made = 0;

    int    mismatches = 0;
    int    in_wait    = 0;
    int    out_wait   = 0;
    int    out_draw;
    bit    in_calm    = 1'b0;
    bit    out_calm   = 1'b0;

    function automatic int eff_count(input int value, input int limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [ncs_pkg::VALUE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return NEG_MAX;
            1:       return POS_MAX;
            2, 3:    return ncs_pkg::VALUE_BITS'($urandom_range(0, 4) - 2);
            default: return ncs_pkg::VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic search_nearest(input ncs_pkg::t_item it);
        int               rows;
        int               dim;
        longint           diff;
        longint unsigned  sum;
        longint unsigned  best;
        ncs_pkg::t_result res;
        if (it.command == ncs_pkg::CMD_CB_WRITE) begin
            codebook[it.row_index][it.element_index] = it.sample_value;
            return;
        end
        query_vec[it.element_index] = it.sample_value;
        rows = eff_count(int'(rows_reg), ncs_pkg::DEF_MAX_ROWS);
        dim  = eff_count(int'(dim_reg), ncs_pkg::DEF_MAX_DIM);
        if (int'(it.element_index) != dim - 1)
            return;
        best = 0;
        res  = '0;
        for (int r = 0; r < rows; r++) begin
            sum = 0;
            for (int e = 0; e < dim; e++) begin
                diff = longint'(codebook[r][e]) - longint'(query_vec[e]);
                sum  = sum + longint'(diff * diff);
                if (sum > DIST_LIMIT)
                    sum = DIST_LIMIT;
            end
            if (r == 0 || sum < best) begin
                best         = sum;
                res.best_row = ncs_pkg::ROW_W'(r);
            end
        end
        res.best_distance = ncs_pkg::DIST_W'(best);
        nearest_expected.push_back(res);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait    <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                search_nearest(i_in);
            if (!i_in_valid || o_in_ready) begin
                if (in_wait != 0) begin
                    in_wait    <= in_wait - 1;
                    i_in_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    if ($urandom_range(0, 63) == 0)
                        in_calm = ~in_calm;
                    i_in       <= items_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    in_wait    <= draw_wait(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait    <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if (nearest_expected.size() == 0) begin
                $error("unexpected transaction: best_row %0d best_distance %0d",
                       o_out.best_row, o_out.best_distance);
                mismatches++;
            end else begin
                if (o_out.best_row !== nearest_expected[0].best_row) begin
                    $error("best_row: expected %0d, actual %0d",
                           nearest_expected[0].best_row, o_out.best_row);
                    mismatches++;
                end
                if (o_out.best_distance !== nearest_expected[0].best_distance) begin
                    $error("best_distance: expected %0d, actual %0d",
                           nearest_expected[0].best_distance, o_out.best_distance);
                    mismatches++;
                end
                void'(nearest_expected.pop_front());
            end
            if ($urandom_range(0, 15) == 0)
                out_calm = ~out_calm;
            out_draw = draw_wait(out_calm);
            out_wait    <= out_draw;
            i_out_ready <= (out_draw == 0);
        end else if (o_out_valid && out_wait != 0) begin
            out_wait    <= out_wait - 1;
            i_out_ready <= (out_wait == 1);
        end else begin
            i_out_ready <= (out_wait == 0);
        end
    end

    function automatic void queue_item(input logic cmd, input int row, input int elem,
                                       input logic [ncs_pkg::VALUE_BITS-1:0] value);
        ncs_pkg::t_item it;
        it.command       = cmd;
        it.row_index     = ncs_pkg::ROW_W'(row);
        it.element_index = ncs_pkg::ELEM_W'(elem);
        it.sample_value  = value;
        if (cmd == ncs_pkg::CMD_CB_WRITE)
            cb_loaded[row][elem] = 1'b1;
        else
            q_loaded[elem] = 1'b1;
        items_to_send.push_back(it);
        items_made++;
    endfunction

    function automatic bit search_safe(input int rows, input int dim);
        for (int r = 0; r < rows; r++)
            for (int e = 0; e < dim; e++)
                if (!cb_loaded[r][e])
                    return 1'b0;
        for (int e = 0; e < dim - 1; e++)
            if (!q_loaded[e])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void send_query(input int dim);
        for (int e = 0; e < dim - 1; e++)
            if (!q_loaded[e] || $urandom_range(0, 3) != 0)
                queue_item(ncs_pkg::CMD_QUERY, $urandom_range(0, 63), e, rand_sample());
        queue_item(ncs_pkg::CMD_QUERY, $urandom_range(0, 63), dim - 1, rand_sample());
    endfunction

    task automatic write_reg(input logic [ncs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ncs_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == ncs_pkg::REG_ROWS_IN_USE)
            rows_reg = value[ncs_pkg::ROWS_CFG_W-1:0];
        else if (idx == ncs_pkg::REG_DIM_IN_USE)
            dim_reg = value[ncs_pkg::DIM_CFG_W-1:0];
    endtask

    task automatic settle();
        while (items_to_send.size() != 0 || i_in_valid || nearest_expected.size() != 0)
            @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [ncs_pkg::CFG_DATA_W-1:0] rows_val,
                             input logic [ncs_pkg::CFG_DATA_W-1:0] dim_val,
                             input int n_items);
        int rows;
        int dim;
        int stop;
        int e;
        settle();
        write_reg(ncs_pkg::REG_ROWS_IN_USE, rows_val);
        write_reg(ncs_pkg::REG_DIM_IN_USE, dim_val);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
                      ncs_pkg::CFG_DATA_W'($urandom));
        rows = eff_count(int'(rows_val), ncs_pkg::DEF_MAX_ROWS);
        dim  = eff_count(int'(dim_val[ncs_pkg::DIM_CFG_W-1:0]), ncs_pkg::DEF_MAX_DIM);
        for (int r = 0; r < rows; r++)
            for (int k = 0; k < dim; k++)
                if (!cb_loaded[r][k])
                    queue_item(ncs_pkg::CMD_CB_WRITE, r, k, rand_sample());
        stop = items_made + n_items;
        while (items_made < stop) begin
            case ($urandom_range(0, 7))
                0: queue_item(ncs_pkg::CMD_CB_WRITE, $urandom_range(0, 63),
                              $urandom_range(0, 15), rand_sample());
                1: queue_item(ncs_pkg::CMD_CB_WRITE, $urandom_range(0, rows - 1),
                              $urandom_range(0, dim - 1), rand_sample());
                2: begin
                    e = $urandom_range(0, 15);
                    if (e != dim - 1 || search_safe(rows, dim))
                        queue_item(ncs_pkg::CMD_QUERY, $urandom_range(0, 63), e,
                                   rand_sample());
                end
                default: send_query(dim);
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        write_reg(ncs_pkg::REG_ROWS_IN_USE, 7'd2);
        write_reg(ncs_pkg::REG_DIM_IN_USE, 7'd2);
        queue_item(ncs_pkg::CMD_CB_WRITE, 0, 0, POS_MAX);
        queue_item(ncs_pkg::CMD_CB_WRITE, 0, 1, NEG_MAX);
        queue_item(ncs_pkg::CMD_CB_WRITE, 1, 0, NEG_MAX);
        queue_item(ncs_pkg::CMD_CB_WRITE, 1, 1, POS_MAX);
        queue_item(ncs_pkg::CMD_QUERY, 63, 0, NEG_MAX);
        queue_item(ncs_pkg::CMD_QUERY, 0, 1, POS_MAX);
        queue_item(ncs_pkg::CMD_QUERY, 21, 0, POS_MAX);
        queue_item(ncs_pkg::CMD_QUERY, 42, 1, NEG_MAX);
        // make both rows equal: tie at the largest distance
        queue_item(ncs_pkg::CMD_CB_WRITE, 1, 0, POS_MAX);
        queue_item(ncs_pkg::CMD_CB_WRITE, 1, 1, NEG_MAX);
        queue_item(ncs_pkg::CMD_QUERY, 5, 0, NEG_MAX);
        queue_item(ncs_pkg::CMD_QUERY, 10, 1, POS_MAX);
        queue_item(ncs_pkg::CMD_QUERY, 63, 15, 16'd5);
        queue_item(ncs_pkg::CMD_CB_WRITE, 63, 15, 16'd1);
        // reuse the stale first element
        queue_item(ncs_pkg::CMD_QUERY, 0, 1, NEG_MAX);
        queue_item(ncs_pkg::CMD_QUERY, 0, 0, 16'd0);
        queue_item(ncs_pkg::CMD_QUERY, 0, 1, 16'd0);
        queue_item(ncs_pkg::CMD_CB_WRITE, 1, 0, 16'hFFFF);
        queue_item(ncs_pkg::CMD_CB_WRITE, 1, 1, 16'd1);
        queue_item(ncs_pkg::CMD_QUERY, 33, 1, 16'd0);

        run_phase(7'd1, 7'd1, 40);
        run_phase(7'd127, 7'd1, 80);
        run_phase(7'd0, 7'd31, 60);
        run_phase(7'd0, 7'd0, 30);
        run_phase(7'd64, 7'h20, 60);
        repeat (5)
            run_phase(ncs_pkg::CFG_DATA_W'($urandom_range(1, 8)),
                      ncs_pkg::CFG_DATA_W'($urandom_range(1, 4) |
                                           ($urandom_range(0, 3) << 5)), 80);
        run_phase(7'd8, 7'd16, 60);
        settle();

        if (mismatches == 0)
            $display("tb_nearest_codeword_mse_search OK");
        else
            $display("tb_nearest_codeword_mse_search NOT OK");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_nearest_codeword_mse_search NOT OK");
        $finish;
    end

endmodule
